// File: design/mbps_pkg.sv
package mbps_pkg;

  // result status codes
  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_STOP  = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_SCAN_MODE     = 3'd0;
  localparam logic [2:0] CFG_PATTERN_BYTES = 3'd1;
  localparam logic [2:0] CFG_CARE_MASK     = 3'd2;
  localparam logic [2:0] CFG_PATTERN_LEN   = 3'd3;
  localparam logic [2:0] CFG_STOP_BYTES    = 3'd4;
  localparam logic [2:0] CFG_STOP_LEN      = 3'd5;
  localparam logic [2:0] CFG_CALL_TARGET   = 3'd6;
  localparam logic [2:0] CFG_REGION_BASE   = 3'd7;

  // near call encoding
  localparam logic [7:0]  OPCODE_CALL = 8'hE8;
  localparam logic [3:0]  CALL_LEN    = 4'd5;
  localparam logic [63:0] CALL_LEN64  = 64'd5;
  // call target reset is zero, stored minus the call length
  localparam logic [63:0] CALL_TGT_M5_RST = 64'hFFFF_FFFF_FFFF_FFFB;

  // longest signature the registers can describe
  localparam logic [3:0] MAX_SIG_LEN = 4'd8;

  typedef struct packed {
    logic       start_req;
    logic [7:0] data_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] match_address;
  } out_word_t;

  typedef struct packed {
    logic        scan_mode;
    logic [63:0] pattern_bytes;
    logic [7:0]  care_mask;
    logic [3:0]  pattern_len;
    logic [63:0] stop_bytes;
    logic [3:0]  stop_len;
    logic [63:0] call_target_m5;
    logic [63:0] region_base;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic stop_hit;
    logic found;
  } verdict_t;

endpackage

// File: design/mbps_cell.sv
module mbps_cell import mbps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctl_t  ctl_i,
  input  logic [7:0] nb_byte_i,
  input  logic [7:0] in_byte_i,
  input  logic [7:0] stop_byte_i,
  input  logic [7:0] pat_byte_i,
  input  logic       care_i,
  output logic [7:0] byte_o,
  output logic       stop_eq_o,
  output logic       pat_ok_o
);

  logic [7:0] byte_q, byte_d;

  // load wins, then clear on a new scan, then shift from the upper neighbor
  always_comb begin
    byte_d = byte_q;
    if (ctl_i.load) begin
      byte_d = in_byte_i;
    end else if (ctl_i.clear) begin
      byte_d = 8'h00;
    end else if (ctl_i.shift) begin
      byte_d = nb_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  // per-byte compares against stop and masked signature
  assign byte_o    = byte_q;
  assign stop_eq_o = (byte_q == stop_byte_i);
  assign pat_ok_o  = !care_i || (byte_q == pat_byte_i);

endmodule

// File: design/mbps_match.sv
module mbps_match import mbps_pkg::*; #(
  parameter int W  = 8,
  parameter int FW = $clog2(W + 1)
) (
  input  logic [4:0][7:0] call_bytes_i,
  input  logic [W-1:0]    stop_eq_i,
  input  logic [W-1:0]    pat_ok_i,
  input  logic [FW-1:0]   fill_i,
  input  cfg_t            cfg_i,
  input  logic [63:0]     addr_i,
  output verdict_t        verdict_o
);

  localparam logic [3:0] WLEN = 4'(W);

  function automatic logic [3:0] eff_len(input logic [3:0] len);
    logic [3:0] n;
    n = (len > MAX_SIG_LEN) ? MAX_SIG_LEN : len;
    return (n > WLEN) ? WLEN : n;
  endfunction

  logic [3:0]  sl, pl, fill4;
  logic [W-1:0] smask, pmask;
  logic [31:0] rel;
  logic [63:0] call_sum;
  logic        stop_hit, pat_hit, call_hit;

  assign sl    = eff_len(cfg_i.stop_len);
  assign pl    = eff_len(cfg_i.pattern_len);
  assign fill4 = 4'(fill_i);

  // bytes that take part in each compare
  always_comb begin
    for (int i = 0; i < W; i++) begin
      smask[i] = (4'(i) < sl);
      pmask[i] = (4'(i) < pl);
    end
  end

  assign stop_hit = (sl != 4'd0) && (sl <= fill4) && (&(stop_eq_i | ~smask));
  assign pat_hit  = (pl <= fill4) && (&(pat_ok_i | ~pmask));

  // rel32 little endian, target compared against call_target - 5
  assign rel      = {call_bytes_i[4], call_bytes_i[3], call_bytes_i[2], call_bytes_i[1]};
  assign call_sum = addr_i + {{32{rel[31]}}, rel};
  assign call_hit = (fill4 >= CALL_LEN) && (call_bytes_i[0] == OPCODE_CALL) &&
                    (call_sum == cfg_i.call_target_m5);

  assign verdict_o.stop_hit = stop_hit;
  assign verdict_o.found    = !stop_hit && (cfg_i.scan_mode ? call_hit : pat_hit);

endmodule

// File: design/masked_byte_pattern_scanner.sv
// Masked byte pattern scanner: looks for the first stream position that
// matches a masked signature, or in call mode an 0xE8 rel32 near call whose
// target equals call_target. A stop signature checked first at each
// position ends the scan with no find.
// Input channel: one word per accepted cycle (start_req, data_byte, last).
// start_req begins a new scan; after a scan has given its result, words are
// taken and dropped until the next start_req.
// Output channel: at most one word per scan (status, match_address).
// Throughput: one byte per cycle while streaming, unless a blocked result
// holds the input. A position is decided the cycle after its window of
// WINDOW_BYTES bytes fills; the result word is registered at the output.
// After the last byte, input stalls while the tail drains: each byte
// still in the window is decided in turn, and an end-of-stream word
// follows if none of them ends the scan.
// Results sit in an output register; input keeps flowing while it waits,
// and only a second result blocked by a stalled receiver holds the scan.
// Reset: registers but out_q take defaults, window empty, scan live at
// offset zero. Config writes must come while idle; this is not checked.
module masked_byte_pattern_scanner import mbps_pkg::*; #(
  parameter int WINDOW_BYTES = 8,
  parameter int OFFSET_BITS  = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  localparam int W  = WINDOW_BYTES;
  localparam int FW = $clog2(W + 1);

  cfg_t                   cfg_q, cfg_d;
  logic [FW-1:0]          fill_q, fill_d, fill_mid, wr_idx;
  logic [OFFSET_BITS-1:0] offset_q, offset_d;
  logic [63:0]            addr_q, addr_d;
  logic                   drain_q, drain_d, done_q, done_d;
  logic                   out_valid_q, out_valid_d;
  out_word_t              out_q, out_d;

  logic [W-1:0][7:0] win, nb;
  logic [W-1:0]      stop_eq, pat_ok;
  cell_ctl_t [W-1:0] cell_ctl;
  verdict_t          verdict;

  logic dec_act, end_req, emit_req, out_free, hold, emit, drop;
  logic in_fire, take, restart, done_after;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCAN_MODE:     cfg_d.scan_mode      = cfg_wdata_i[0];
        CFG_PATTERN_BYTES: cfg_d.pattern_bytes  = cfg_wdata_i;
        CFG_CARE_MASK:     cfg_d.care_mask      = cfg_wdata_i[7:0];
        CFG_PATTERN_LEN:   cfg_d.pattern_len    = cfg_wdata_i[3:0];
        CFG_STOP_BYTES:    cfg_d.stop_bytes     = cfg_wdata_i;
        CFG_STOP_LEN:      cfg_d.stop_len       = cfg_wdata_i[3:0];
        CFG_CALL_TARGET:   cfg_d.call_target_m5 = cfg_wdata_i - CALL_LEN64;
        CFG_REGION_BASE:   cfg_d.region_base    = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // chain of window cells, byte 0 is the current position
  for (genvar i = 0; i < W; i++) begin : g_cell
    if (i == W - 1) begin : g_top
      assign nb[i] = 8'h00;
    end else begin : g_mid
      assign nb[i] = win[i+1];
    end
    assign cell_ctl[i].clear = restart;
    assign cell_ctl[i].load  = take && (wr_idx == FW'(i));
    assign cell_ctl[i].shift = drop;

    mbps_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (cell_ctl[i]),
      .nb_byte_i   (nb[i]),
      .in_byte_i   (in_data_i.data_byte),
      .stop_byte_i (cfg_q.stop_bytes[8*i +: 8]),
      .pat_byte_i  (cfg_q.pattern_bytes[8*i +: 8]),
      .care_i      (cfg_q.care_mask[i]),
      .byte_o      (win[i]),
      .stop_eq_o   (stop_eq[i]),
      .pat_ok_o    (pat_ok[i])
    );
  end

  mbps_match #(
    .W  (W),
    .FW (FW)
  ) u_match (
    .call_bytes_i ({win[4], win[3], win[2], win[1], win[0]}),
    .stop_eq_i    (stop_eq),
    .pat_ok_i     (pat_ok),
    .fill_i       (fill_q),
    .cfg_i        (cfg_q),
    .addr_i       (addr_q),
    .verdict_o    (verdict)
  );

  // decide the head when the window is full or while draining the tail
  assign dec_act  = !done_q && ((fill_q == FW'(W)) || (drain_q && (fill_q != '0)));
  assign end_req  = !done_q && drain_q && (fill_q == '0);
  assign emit_req = (dec_act && (verdict.found || verdict.stop_hit)) || end_req;
  assign out_free = !out_valid_q || !out_stall_i;
  assign hold     = emit_req && !out_free;
  assign emit     = emit_req && !hold;
  assign drop     = dec_act && !verdict.found && !verdict.stop_hit;

  // input side
  assign in_stall_o = drain_q || hold;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign done_after = done_q || emit;
  assign restart    = in_fire && in_data_i.start_req;
  assign take       = in_fire && (in_data_i.start_req || !done_after);
  assign fill_mid   = fill_q - FW'(drop);
  assign wr_idx     = restart ? '0 : fill_mid;

  // scan state
  always_comb begin
    fill_d   = fill_mid;
    offset_d = offset_q;
    addr_d   = addr_q;
    drain_d  = drain_q;
    done_d   = done_after;
    if (emit) begin
      drain_d = 1'b0;
    end
    if (restart) begin
      fill_d   = FW'(1);
      offset_d = '0;
      addr_d   = cfg_q.region_base;
      drain_d  = in_data_i.last;
      done_d   = 1'b0;
    end else begin
      if (take) begin
        fill_d = fill_mid + FW'(1);
        if (in_data_i.last) begin
          drain_d = 1'b1;
        end
      end
      if (drop) begin
        offset_d = offset_q + OFFSET_BITS'(1);
        // offset wraps, the address follows it back to the base
        addr_d   = (offset_q == '1) ? cfg_q.region_base : addr_q + 64'd1;
      end else if (cfg_we_i && (cfg_idx_i == CFG_REGION_BASE)) begin
        addr_d = cfg_wdata_i + 64'(offset_q);
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (end_req) begin
        out_d.status        = ST_END;
        out_d.match_address = '0;
      end else if (verdict.stop_hit) begin
        out_d.status        = ST_STOP;
        out_d.match_address = '0;
      end else begin
        out_d.status        = ST_FOUND;
        out_d.match_address = addr_q;
      end
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scan_mode      <= 1'b0;
      cfg_q.pattern_bytes  <= '0;
      cfg_q.care_mask      <= 8'hFF;
      cfg_q.pattern_len    <= 4'd1;
      cfg_q.stop_bytes     <= '0;
      cfg_q.stop_len       <= 4'd1;
      cfg_q.call_target_m5 <= CALL_TGT_M5_RST;
      cfg_q.region_base    <= '0;
      fill_q               <= '0;
      offset_q             <= '0;
      addr_q               <= '0;
      drain_q              <= 1'b0;
      done_q               <= 1'b0;
      out_valid_q          <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      fill_q      <= fill_d;
      offset_q    <= offset_d;
      addr_q      <= addr_d;
      drain_q     <= drain_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // a result closes the scan unless a new one starts with it
  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !restart |=> done_q)
    else $error("scan not closed after result");

  // a dropped head shrinks the window by one when no byte comes in
  a_drop_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop && !in_fire |=> fill_q == $past(fill_q) - 1'b1)
    else $error("window fill wrong after drop");

  // a blocked result freezes the scan
  a_hold_frz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold |=> $stable(fill_q) && $stable(offset_q) && $stable(done_q))
    else $error("scan moved while result blocked");

  // only a find carries an address
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_FOUND) |-> out_data_o.match_address == '0)
    else $error("address on non-find result");
`endif

endmodule
